@@ hdl/two_state_kalman_filter_unit_defines.svh @@
// Assertion macros shared by the checker of the two-state Kalman filter unit.
`ifndef TWO_STATE_KALMAN_FILTER_UNIT_DEFINES_SVH
`define TWO_STATE_KALMAN_FILTER_UNIT_DEFINES_SVH

// Consequent must hold in the clock after the antecedent.
`define TSKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same clock as the antecedent.
`define TSKF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/tskf_pkg.sv @@
// Package with shared types and constants of the two-state Kalman filter unit.
`timescale 1ns / 1ps

package tskf_pkg;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 1'b1;

  // Request commands.
  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Result status codes.
  localparam int STAT_W = 2;
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONPOS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT    = 2'd2;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_BP,
    ST_S2,
    ST_Q1,
    ST_Q2,
    ST_T,
    ST_MAA,
    ST_MAB1,
    ST_MAB2,
    ST_MBA,
    ST_MBB1,
    ST_MBB2,
    ST_MBB3,
    ST_CHK,
    ST_DIVA,
    ST_WAITA,
    ST_DIVB,
    ST_WAITB,
    ST_Y,
    ST_NA,
    ST_NB,
    ST_PAA,
    ST_PAB,
    ST_PBA,
    ST_PBB,
    ST_OUT
  } tskf_state_t;

endpackage

@@ hdl/two_state_kalman_filter_unit.sv @@
// Top level of the two-state Kalman filter: sequencer, state and shared datapath.
`timescale 1ns / 1ps
//
// Two-state (value and its time integral) Kalman filter in signed fixed point.
// Input channel: in_valid/in_stall with in_cmd, in_measurement, in_noise_sigma.
// A request with command 0 loads the estimate from the measurement; command 1
// runs one predict and update step. Every request returns exactly one result
// on out_valid/out_stall: both estimates, both gains, the first variance and
// a status code.
// A step runs nineteen operations on one shared multiply/add unit, each
// a multiply phase and a write phase, and the bit-serial divider forms
// both gains in turn. A new request is taken only once the last result has
// left the sequencer; in_stall is high while a request is in work. A result
// sits in the output register until taken; if the receiver stalls, the
// finished next result waits in the sequencer.
// Reset (synchronous, active low) clears the estimate and covariance to zero
// and loads time_step = 0.1 and meas_noise_var = 0.0144. Configuration writes
// via cfg_we/cfg_index/cfg_wdata are to be done while the block is idle.
//
module two_state_kalman_filter_unit #(
  parameter int DATA_WIDTH = tskf_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = tskf_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tskf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [DATA_WIDTH-2:0]             cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [DATA_WIDTH-1:0]      in_measurement,
  input  logic signed [DATA_WIDTH-1:0]      in_noise_sigma,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_primary,
  output logic signed [DATA_WIDTH-1:0]      out_integrated,
  output logic signed [DATA_WIDTH-1:0]      out_gain_primary,
  output logic signed [DATA_WIDTH-1:0]      out_gain_integrated,
  output logic signed [DATA_WIDTH-1:0]      out_variance_primary,
  output logic [tskf_pkg::STAT_W-1:0]       out_status
);

  localparam int W  = DATA_WIDTH;
  localparam int AW = 2 * DATA_WIDTH - FRAC_BITS + 2;
  localparam logic [63:0] TS_RST64 = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] R_RST64  = (64'd144 * (64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic signed [AW-1:0] SMAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] SMIN = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [AW-1:0] ext(input logic signed [W-1:0] v);
    ext = {{(AW-W){v[W-1]}}, v};
  endfunction

  tskf_pkg::tskf_state_t state_r, state_nxt;
  logic ph_r, ph_nxt;

  // Configuration registers.
  logic [W-2:0] ts_r;
  logic [W-2:0] mnv_r;

  // Filter state and step temporaries.
  logic signed [W-1:0] ep_r, ei_r, paa_r, pab_r, pba_r, pbb_r;
  logic signed [W-1:0] meas_r, sig_r;
  logic signed [W-1:0] bp_r, s2_r, q1_r, q2_r, t_r, tmp_r;
  logic signed [W-1:0] maa_r, mab_r, mba_r, mbb_r, y_r, ka_r, kb_r;
  logic signed [AW-1:0] w_r;
  logic signed [W:0]    s_r;
  logic                 cmd_r, satf_r, nonpos_r;

  // Output register.
  logic                  out_valid_r;
  logic signed [W-1:0]   o_a_r, o_b_r, o_ka_r, o_kb_r, o_var_r;
  logic [tskf_pkg::STAT_W-1:0] o_st_r;

  // Shared unit signals.
  logic signed [W-1:0]  mul_a, mul_b;
  logic                 use_mul, neg_mul, sat_op;
  logic signed [AW-1:0] add_a, add_b, prod, pterm, sum;
  logic signed [W-1:0]  sat_val;
  logic                 sat_hit;
  logic signed [W-1:0]  dt_s, r_s;
  logic signed [W:0]    s_now;
  logic                 in_acc, out_free, alu_wr;
  logic                 div_start, div_done, div_ovf;
  logic signed [W-1:0]  div_num, div_quo;

  assign dt_s     = {1'b0, ts_r};
  assign r_s      = {1'b0, mnv_r};
  assign in_stall = (state_r != tskf_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign alu_wr   = ph_r;

  tskf_mul_unit #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (AW)
  ) u_mul (
    .clk (clk),
    .en  (!ph_r),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  tskf_div_unit #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (s_r[W-1:0]),
    .done (div_done),
    .quo  (div_quo),
    .ovf  (div_ovf)
  );

  // Operand selection for the shared multiply/add unit.
  always_comb begin
    mul_a   = dt_s;
    mul_b   = '0;
    use_mul = 1'b0;
    neg_mul = 1'b0;
    sat_op  = 1'b1;
    add_a   = '0;
    add_b   = '0;
    unique case (state_r)
      tskf_pkg::ST_BP:   begin mul_b = ep_r; use_mul = 1'b1; add_a = ext(ei_r); end
      tskf_pkg::ST_S2:   begin mul_a = sig_r; mul_b = sig_r; use_mul = 1'b1; end
      tskf_pkg::ST_Q1:   begin mul_b = s2_r; use_mul = 1'b1; end
      tskf_pkg::ST_Q2:   begin mul_b = q1_r; use_mul = 1'b1; end
      tskf_pkg::ST_T:    begin mul_b = paa_r; use_mul = 1'b1; add_a = ext(pba_r); end
      tskf_pkg::ST_MAA:  begin add_a = ext(paa_r); add_b = ext(q2_r); end
      tskf_pkg::ST_MAB1: begin mul_b = paa_r; use_mul = 1'b1; add_a = ext(pab_r); end
      tskf_pkg::ST_MAB2: begin add_a = ext(tmp_r); add_b = ext(q1_r); end
      tskf_pkg::ST_MBA:  begin add_a = ext(t_r); add_b = ext(q1_r); end
      tskf_pkg::ST_MBB1: begin
        mul_b = pab_r; use_mul = 1'b1; add_a = ext(pbb_r); sat_op = 1'b0;
      end
      tskf_pkg::ST_MBB2: begin mul_b = t_r; use_mul = 1'b1; add_a = w_r; end
      tskf_pkg::ST_MBB3: begin add_a = ext(tmp_r); add_b = ext(s2_r); end
      tskf_pkg::ST_Y:    begin add_a = ext(meas_r); add_b = -ext(ep_r); end
      tskf_pkg::ST_NA:   begin
        mul_a = ka_r; mul_b = y_r; use_mul = 1'b1; add_a = ext(ep_r);
      end
      tskf_pkg::ST_NB:   begin
        mul_a = kb_r; mul_b = y_r; use_mul = 1'b1; add_a = ext(bp_r);
      end
      tskf_pkg::ST_PAA:  begin
        mul_a = ka_r; mul_b = maa_r; use_mul = 1'b1; neg_mul = 1'b1; add_a = ext(maa_r);
      end
      tskf_pkg::ST_PAB:  begin
        mul_a = ka_r; mul_b = mab_r; use_mul = 1'b1; neg_mul = 1'b1; add_a = ext(mab_r);
      end
      tskf_pkg::ST_PBA:  begin
        mul_a = kb_r; mul_b = maa_r; use_mul = 1'b1; neg_mul = 1'b1; add_a = ext(mba_r);
      end
      tskf_pkg::ST_PBB:  begin
        mul_a = kb_r; mul_b = mab_r; use_mul = 1'b1; neg_mul = 1'b1; add_a = ext(mbb_r);
      end
      default: begin
        sat_op = 1'b0;
      end
    endcase
  end

  // Exact sum of the scaled product and the addends, then saturation.
  assign pterm   = use_mul ? (neg_mul ? -prod : prod) : '0;
  assign sum     = pterm + add_a + add_b;
  assign sat_val = (sum > SMAX) ? SMAX[W-1:0] : ((sum < SMIN) ? SMIN[W-1:0] : sum[W-1:0]);
  assign sat_hit = sat_op && alu_wr && ((sum > SMAX) || (sum < SMIN));

  // Innovation variance, kept one bit wider than a word.
  assign s_now = {maa_r[W-1], maa_r} + {2'b00, mnv_r};

  assign div_start = (state_r == tskf_pkg::ST_DIVA) || (state_r == tskf_pkg::ST_DIVB);
  assign div_num   = (state_r == tskf_pkg::ST_DIVB) ? mba_r : maa_r;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tskf_pkg::ST_IDLE;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  // Next state: a multiply phase and a write phase per shared-unit operation, waits on the divider.
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = 1'b0;
    unique case (state_r)
      tskf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_cmd == tskf_pkg::CMD_INIT) ? tskf_pkg::ST_INIT : tskf_pkg::ST_BP;
        end
      end
      tskf_pkg::ST_INIT: state_nxt = tskf_pkg::ST_OUT;
      tskf_pkg::ST_CHK: begin
        state_nxt = (!s_now[W] && (s_now != '0)) ? tskf_pkg::ST_DIVA : tskf_pkg::ST_OUT;
      end
      tskf_pkg::ST_DIVA: state_nxt = tskf_pkg::ST_WAITA;
      tskf_pkg::ST_WAITA: begin
        if (div_done) begin
          state_nxt = tskf_pkg::ST_DIVB;
        end
      end
      tskf_pkg::ST_DIVB: state_nxt = tskf_pkg::ST_WAITB;
      tskf_pkg::ST_WAITB: begin
        if (div_done) begin
          state_nxt = tskf_pkg::ST_Y;
        end
      end
      tskf_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = tskf_pkg::ST_IDLE;
        end
      end
      default: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          unique case (state_r)
            tskf_pkg::ST_BP:   state_nxt = tskf_pkg::ST_S2;
            tskf_pkg::ST_S2:   state_nxt = tskf_pkg::ST_Q1;
            tskf_pkg::ST_Q1:   state_nxt = tskf_pkg::ST_Q2;
            tskf_pkg::ST_Q2:   state_nxt = tskf_pkg::ST_T;
            tskf_pkg::ST_T:    state_nxt = tskf_pkg::ST_MAA;
            tskf_pkg::ST_MAA:  state_nxt = tskf_pkg::ST_MAB1;
            tskf_pkg::ST_MAB1: state_nxt = tskf_pkg::ST_MAB2;
            tskf_pkg::ST_MAB2: state_nxt = tskf_pkg::ST_MBA;
            tskf_pkg::ST_MBA:  state_nxt = tskf_pkg::ST_MBB1;
            tskf_pkg::ST_MBB1: state_nxt = tskf_pkg::ST_MBB2;
            tskf_pkg::ST_MBB2: state_nxt = tskf_pkg::ST_MBB3;
            tskf_pkg::ST_MBB3: state_nxt = tskf_pkg::ST_CHK;
            tskf_pkg::ST_Y:    state_nxt = tskf_pkg::ST_NA;
            tskf_pkg::ST_NA:   state_nxt = tskf_pkg::ST_NB;
            tskf_pkg::ST_NB:   state_nxt = tskf_pkg::ST_PAA;
            tskf_pkg::ST_PAA:  state_nxt = tskf_pkg::ST_PAB;
            tskf_pkg::ST_PAB:  state_nxt = tskf_pkg::ST_PBA;
            tskf_pkg::ST_PBA:  state_nxt = tskf_pkg::ST_PBB;
            default:           state_nxt = tskf_pkg::ST_OUT;
          endcase
        end
      end
    endcase
  end

  // Configuration registers, loaded with defaults by reset, and filter state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= TS_RST64[W-2:0];
      mnv_r <= R_RST64[W-2:0];
      ep_r  <= '0;
      ei_r  <= '0;
      paa_r <= '0;
      pab_r <= '0;
      pba_r <= '0;
      pbb_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tskf_pkg::REG_TIME_STEP:  ts_r  <= cfg_wdata;
          tskf_pkg::REG_MEAS_NOISE: mnv_r <= cfg_wdata;
        endcase
      end
      if (state_r == tskf_pkg::ST_INIT) begin
        ep_r  <= meas_r;
        ei_r  <= '0;
        paa_r <= r_s;
        pab_r <= '0;
        pba_r <= '0;
        pbb_r <= '0;
      end else if (alu_wr) begin
        unique case (state_r)
          tskf_pkg::ST_NA:  ep_r  <= sat_val;
          tskf_pkg::ST_NB:  ei_r  <= sat_val;
          tskf_pkg::ST_PAA: paa_r <= sat_val;
          tskf_pkg::ST_PAB: pab_r <= sat_val;
          tskf_pkg::ST_PBA: pba_r <= sat_val;
          tskf_pkg::ST_PBB: pbb_r <= sat_val;
          default: ;
        endcase
      end
    end
  end

  // Request capture and step temporaries.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_cmd;
      meas_r   <= in_measurement;
      sig_r    <= in_noise_sigma;
      satf_r   <= 1'b0;
      nonpos_r <= 1'b0;
    end
    if (sat_hit || (div_done && div_ovf)) begin
      satf_r <= 1'b1;
    end
    if (state_r == tskf_pkg::ST_INIT) begin
      ka_r <= '0;
      kb_r <= '0;
    end
    if (state_r == tskf_pkg::ST_CHK) begin
      s_r <= s_now;
      if (s_now[W] || (s_now == '0)) begin
        nonpos_r <= 1'b1;
        ka_r     <= '0;
        kb_r     <= '0;
      end
    end
    if (div_done && (state_r == tskf_pkg::ST_WAITA)) begin
      ka_r <= div_quo;
    end
    if (div_done && (state_r == tskf_pkg::ST_WAITB)) begin
      kb_r <= div_quo;
    end
    if (alu_wr) begin
      unique case (state_r)
        tskf_pkg::ST_BP:   bp_r  <= sat_val;
        tskf_pkg::ST_S2:   s2_r  <= sat_val;
        tskf_pkg::ST_Q1:   q1_r  <= sat_val;
        tskf_pkg::ST_Q2:   q2_r  <= sat_val;
        tskf_pkg::ST_T:    t_r   <= sat_val;
        tskf_pkg::ST_MAA:  maa_r <= sat_val;
        tskf_pkg::ST_MAB1: tmp_r <= sat_val;
        tskf_pkg::ST_MAB2: mab_r <= sat_val;
        tskf_pkg::ST_MBA:  mba_r <= sat_val;
        tskf_pkg::ST_MBB1: w_r   <= sum;
        tskf_pkg::ST_MBB2: tmp_r <= sat_val;
        tskf_pkg::ST_MBB3: mbb_r <= sat_val;
        tskf_pkg::ST_Y:    y_r   <= sat_val;
        default: ;
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == tskf_pkg::ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == tskf_pkg::ST_OUT) && out_free) begin
      o_a_r   <= ep_r;
      o_b_r   <= ei_r;
      o_ka_r  <= ka_r;
      o_kb_r  <= kb_r;
      o_var_r <= paa_r;
      if (cmd_r == tskf_pkg::CMD_INIT) begin
        o_st_r <= tskf_pkg::STAT_OK;
      end else if (nonpos_r) begin
        o_st_r <= tskf_pkg::STAT_NONPOS;
      end else if (satf_r) begin
        o_st_r <= tskf_pkg::STAT_SAT;
      end else begin
        o_st_r <= tskf_pkg::STAT_OK;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_primary          = o_a_r;
  assign out_integrated       = o_b_r;
  assign out_gain_primary     = o_ka_r;
  assign out_gain_integrated  = o_kb_r;
  assign out_variance_primary = o_var_r;
  assign out_status           = o_st_r;

endmodule

@@ hdl/tskf_mul_unit.sv @@
// Shared signed multiplier with floor scaling and a registered product.
`timescale 1ns / 1ps

module tskf_mul_unit #(
  parameter int DATA_WIDTH = tskf_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = tskf_pkg::DEF_FRAC_BITS,
  parameter int ACC_W      = 2 * DATA_WIDTH - FRAC_BITS + 2
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [ACC_W-1:0]      prod
);

  logic signed [2*DATA_WIDTH-1:0] full;
  logic signed [2*DATA_WIDTH-1:0] scaled;
  logic signed [ACC_W-1:0]        prod_r;

  // Exact product, then an arithmetic shift that rounds toward minus infinity.
  assign full   = a * b;
  assign scaled = full >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= scaled[ACC_W-1:0];
    end
  end

  assign prod = prod_r;

endmodule

@@ hdl/tskf_div_unit.sv @@
// Radix-2 restoring divider that forms the saturated fixed-point gain quotient.
`timescale 1ns / 1ps

module tskf_div_unit #(
  parameter int DATA_WIDTH = tskf_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = tskf_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic        [DATA_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quo,
  output logic                         ovf
);

  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic [NW-1:0] LIM = {{(NW-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);
  localparam logic signed [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] QMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [NW-1:0]         n_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] d_r;
  logic                  neg_r;
  logic [CW-1:0]         cnt_r;
  logic                  run_r;
  logic                  fin_r;
  logic                  done_r;
  logic signed [DATA_WIDTH-1:0] quo_r;
  logic                  ovf_r;

  logic [DATA_WIDTH-1:0] mag;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   rem_sub;
  logic                  ge;

  // Magnitude of the dividend; the most negative value still fits unsigned.
  assign mag     = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : DATA_WIDTH'(num);
  assign rem_sh  = {rem_r, n_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign ge      = (rem_sh >= {1'b0, d_r});

  // Control: one quotient bit per cycle, then the quotient is signed and saturated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the quotient into the dividend register.
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {mag, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      d_r   <= den;
      neg_r <= num[DATA_WIDTH-1];
    end else if (run_r) begin
      rem_r <= ge ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
      n_r   <= {n_r[NW-2:0], ge};
    end
    if (fin_r) begin
      if (neg_r) begin
        ovf_r <= (n_r > LIM);
        quo_r <= (n_r > LIM) ? QMIN : DATA_WIDTH'(-n_r[DATA_WIDTH-1:0]);
      end else begin
        ovf_r <= (n_r > LIM - 1'b1);
        quo_r <= (n_r > LIM - 1'b1) ? QMAX : n_r[DATA_WIDTH-1:0];
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign ovf  = ovf_r;

endmodule

@@ hdl/tskf_checker.sv @@
// Port-level checker for the two-state Kalman filter unit, with its bind.
`timescale 1ns / 1ps
`include "two_state_kalman_filter_unit_defines.svh"

module tskf_checker #(
  parameter int DATA_WIDTH = tskf_pkg::DEF_DATA_WIDTH
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [DATA_WIDTH-1:0]   out_primary,
  input logic signed [DATA_WIDTH-1:0]   out_gain_primary,
  input logic signed [DATA_WIDTH-1:0]   out_gain_integrated,
  input logic [tskf_pkg::STAT_W-1:0]    out_status
);

  // An accepted request keeps the block busy for the next cycle.
  `TSKF_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "ready right after a request")

  // A stalled result holds.
  `TSKF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_primary), "result changed under stall")

  // The status code never takes the unused value.
  `TSKF_ASSERT_SAME(a_status_code, out_valid, out_status != 2'd3, "unused status code")

  // A held step reports zero gains.
  `TSKF_ASSERT_SAME(a_nonpos_gain, out_valid && (out_status == tskf_pkg::STAT_NONPOS), (out_gain_primary == '0) && (out_gain_integrated == '0), "nonzero gain on held step")

endmodule

bind two_state_kalman_filter_unit tskf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_tskf_checker (.*);

@@ bench/tb_two_state_kalman_filter_unit.sv @@
// Self-checking testbench for the two-state Kalman filter unit.
`timescale 1ns / 1ps

module tb_two_state_kalman_filter_unit;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [DW-1:0] primary;
    logic signed [DW-1:0] integrated;
    logic signed [DW-1:0] gain_a;
    logic signed [DW-1:0] gain_b;
    logic signed [DW-1:0] var_a;
    logic [tskf_pkg::STAT_W-1:0] status;
  } filter_result_t;

  // Filter predictor and the queue of estimates still owed by the block.
  class kalman_scoreboard;
    longint dt, r;
    longint est_a, est_b, paa, pab, pba, pbb;
    bit clipped;
    filter_result_t pending[$];
    int mismatches;

    function new();
      dt = 6554; r = 944;
      est_a = 0; est_b = 0; paa = 0; pab = 0; pba = 0; pbb = 0;
      mismatches = 0;
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) begin clipped = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin clipped = 1; return -64'sd2147483648; end
      return v;
    endfunction

    // Product shifted down with rounding toward minus infinity.
    function longint fmul(longint a, longint b);
      return (a * b) >>> FB;
    endfunction

    function void write_reg(logic [tskf_pkg::CFG_IDX_W-1:0] idx, longint val);
      if (idx == tskf_pkg::REG_TIME_STEP) dt = val;
      else if (idx == tskf_pkg::REG_MEAS_NOISE) r = val;
    endfunction

    function void note_request(logic cmd, logic signed [DW-1:0] meas_in,
                               logic signed [DW-1:0] sigma_in);
      longint meas, sg, bp, s2, q1, q2, t, maa, mab, mba, mbb, s, ka, kb, y, na, nb;
      filter_result_t res;
      meas = meas_in; sg = sigma_in;
      clipped = 0;
      if (cmd == tskf_pkg::CMD_INIT) begin
        est_a = meas; est_b = 0;
        paa = clip(r); pab = 0; pba = 0; pbb = 0;
        res = '{DW'(est_a), '0, '0, '0, DW'(paa), tskf_pkg::STAT_OK};
        pending.push_back(res);
        return;
      end
      bp = clip(fmul(dt, est_a) + est_b);
      s2 = clip(fmul(sg, sg));
      q1 = clip(fmul(dt, s2));
      q2 = clip(fmul(dt, q1));
      t = clip(fmul(dt, paa) + pba);
      maa = clip(paa + q2);
      mab = clip(clip(fmul(dt, paa) + pab) + q1);
      mba = clip(t + q1);
      mbb = clip(clip(fmul(dt, t) + fmul(dt, pab) + pbb) + s2);
      s = maa + r;
      if (s <= 0) begin
        res = '{DW'(est_a), DW'(est_b), '0, '0, DW'(paa), tskf_pkg::STAT_NONPOS};
        pending.push_back(res);
        return;
      end
      ka = clip((maa * 65536) / s);
      kb = clip((mba * 65536) / s);
      y = clip(meas - est_a);
      na = clip(est_a + fmul(ka, y));
      nb = clip(bp + fmul(kb, y));
      est_a = na; est_b = nb;
      paa = clip(maa - fmul(ka, maa));
      pab = clip(mab - fmul(ka, mab));
      pba = clip(mba - fmul(kb, maa));
      pbb = clip(mbb - fmul(kb, mab));
      res = '{DW'(na), DW'(nb), DW'(ka), DW'(kb), DW'(paa),
              clipped ? tskf_pkg::STAT_SAT : tskf_pkg::STAT_OK};
      pending.push_back(res);
    endfunction

    function void check_result(filter_result_t got);
      filter_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch\n  expected %h %h %h %h %h %0d\n  actual   %h %h %h %h %h %0d",
                   want.primary, want.integrated, want.gain_a, want.gain_b, want.var_a,
                   want.status, got.primary, got.integrated, got.gain_a, got.gain_b,
                   got.var_a, got.status);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [tskf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [DW-2:0] cfg_wdata = '0;
  logic in_valid = 0, in_cmd = 0, out_stall = 0;
  logic signed [DW-1:0] in_measurement = '0, in_noise_sigma = '0;
  logic in_stall, out_valid;
  logic signed [DW-1:0] out_primary, out_integrated, out_gain_primary;
  logic signed [DW-1:0] out_gain_integrated, out_variance_primary;
  logic [tskf_pkg::STAT_W-1:0] out_status;

  kalman_scoreboard sb = new();
  int idle_pct = 29;
  int quiet_cycles = 0;

  two_state_kalman_filter_unit DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Result side: random stall, check each accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_primary, out_integrated, out_gain_primary,
                        out_gain_integrated, out_variance_primary, out_status});
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The block is busy in the cycle after a request, so the closing cycle costs no rate.
  task automatic send_request(logic cmd, logic signed [DW-1:0] m, logic signed [DW-1:0] s);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1; in_cmd <= cmd; in_measurement <= m; in_noise_sigma <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(cmd, m, s);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_cfg(logic [tskf_pkg::CFG_IDX_W-1:0] idx, logic [DW-2:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, longint'(val));
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(131072) - 65536;
      1: return $signed($urandom) >>> $urandom_range(20, 8);
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Random phase: mostly steps, with an occasional initialize.
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_request(($urandom_range(15) == 0) ? tskf_pkg::CMD_INIT : tskf_pkg::CMD_STEP,
                   rand_word(), rand_word());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: step before any initialize, then extremes.
    send_request(tskf_pkg::CMD_STEP, 32'sh00010000, 32'sh00001000);
    send_request(tskf_pkg::CMD_INIT, 32'sh7fffffff, 32'sh0);
    send_request(tskf_pkg::CMD_STEP, 32'sh80000000, 32'sh7fffffff);
    send_request(tskf_pkg::CMD_STEP, 32'sh7fffffff, 32'sh80000000);
    send_request(tskf_pkg::CMD_INIT, 32'sh80000000, 32'shffffffff);
    send_request(tskf_pkg::CMD_STEP, 32'sh0, 32'sh0);
    drain();
    // Zero noise and zero sigma leaves S at zero: held state.
    write_cfg(tskf_pkg::REG_MEAS_NOISE, '0);
    write_cfg(tskf_pkg::REG_TIME_STEP, '0);
    send_request(tskf_pkg::CMD_INIT, 32'sh00020000, 32'sh0);
    send_request(tskf_pkg::CMD_STEP, 32'sh00030000, 32'sh0);
    send_request(tskf_pkg::CMD_STEP, 32'sh00030000, 32'sh00010000);
    drain();
    write_cfg(tskf_pkg::REG_TIME_STEP, 31'h7fffffff);
    write_cfg(tskf_pkg::REG_MEAS_NOISE, 31'h7fffffff);
    send_request(tskf_pkg::CMD_INIT, 32'sh00010000, 32'sh0);
    send_request(tskf_pkg::CMD_STEP, 32'sh7fffffff, 32'sh7fffffff);
    send_request(tskf_pkg::CMD_STEP, 32'sh80000000, 32'sh00010000);
    drain();
    write_cfg(tskf_pkg::REG_TIME_STEP, 31'd6554);
    write_cfg(tskf_pkg::REG_MEAS_NOISE, 31'd944);
    // Stretch with no idling, then the random phases.
    idle_pct = 0;
    random_phase(150);
    idle_pct = 29;
    random_phase(700);
    drain();
    write_cfg(tskf_pkg::REG_TIME_STEP, (DW-1)'($urandom_range(131072)));
    write_cfg(tskf_pkg::REG_MEAS_NOISE, (DW-1)'($urandom_range(200000)));
    random_phase(600);
    drain();
    write_cfg(tskf_pkg::REG_TIME_STEP, (DW-1)'($urandom));
    write_cfg(tskf_pkg::REG_MEAS_NOISE, (DW-1)'($urandom));
    random_phase(380);
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
